/* hw/rtl/rwrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_pkg
// Shared types and widths of the running and window regression slope block.
// ----------------------------------------------------------------------------
package rwrs_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MEAN_W   = 48;
	localparam int DIFF_W   = 49;
	localparam int MOM_W    = 64;
	localparam int SUM_W    = 64;
	localparam int WIDE_W   = 128;
	localparam int PAIR_W   = 64;

	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] response;
		logic signed [SAMPLE_W-1:0] predictor;
		logic                       skip;
	} rwrs_item_t;

	typedef struct packed {
		logic [31:0]                count;
		logic signed [SAMPLE_W-1:0] total_slope;
		logic                       total_valid;
		logic signed [SAMPLE_W-1:0] window_slope;
		logic                       window_valid;
	} rwrs_result_t;

endpackage

/* hw/rtl/rwrs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rwrs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/rwrs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_front
// Input side: takes requests and holds them in a two-entry queue for the back.
// ----------------------------------------------------------------------------
module rwrs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [31:0]         response_sample,
	input  logic signed [31:0]         predictor_sample,
	input  logic                       skip_sample,
	output logic                       queue_valid,
	input  logic                       queue_ready,
	output rwrs_pkg::rwrs_item_t       queue_item
);
	import rwrs_pkg::*;

	rwrs_item_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] level_q;
	logic       push;
	logic       pop;

	assign sample_ready = (level_q != 2'd2);
	assign queue_valid  = (level_q != 2'd0);
	assign queue_item   = entry_q[rd_ptr_q];
	assign push         = sample_valid && sample_ready;
	assign pop          = queue_valid && queue_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= '{response: response_sample,
			                       predictor: predictor_sample,
			                       skip: skip_sample};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			level_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				level_q <= level_q + 2'd1;
			end else if (pop && !push) begin
				level_q <= level_q - 2'd1;
			end
		end
	end

endmodule

/* hw/rtl/rwrs_sdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_sdiv
// Serial signed divider for the mean update, one quotient bit per cycle,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module rwrs_sdiv (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [rwrs_pkg::DIFF_W-1:0]    dividend,
	input  logic [31:0]                           divisor,
	output logic                                  busy,
	output logic signed [rwrs_pkg::DIFF_W-1:0]    quotient
);
	import rwrs_pkg::*;

	localparam int CNT_W = $clog2(DIFF_W + 1);

	logic              busy_q;
	logic              neg_q;
	logic [31:0]       div_q;
	logic [31:0]       rem_q;
	logic [DIFF_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [32:0]       trial;
	logic              ge;

	assign trial    = {rem_q, quo_q[DIFF_W-1]};
	assign ge       = (trial >= {1'b0, div_q});
	assign busy     = busy_q;
	assign quotient = neg_q ? -signed'(quo_q) : signed'(quo_q);

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DIFF_W-1];
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend[DIFF_W-1] ? -dividend : dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quo_q <= {quo_q[DIFF_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIFF_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/rwrs_qdiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_qdiv
// Serial Q16.16 slope divider: num * 2^16 / den for den > 0, one bit per
// cycle, truncated toward zero and saturated to the signed 32-bit range.
// ----------------------------------------------------------------------------
module rwrs_qdiv (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [rwrs_pkg::WIDE_W-1:0] num,
	input  logic [rwrs_pkg::WIDE_W-1:0]        den,
	output logic                               busy,
	output logic signed [31:0]                 slope
);
	import rwrs_pkg::*;

	logic              busy_q;
	logic              neg_q;
	logic [WIDE_W-1:0] rem_q;
	logic [WIDE_W-1:0] sub_q;
	logic [32:0]       q_q;
	logic [5:0]        cnt_q;
	logic [WIDE_W-1:0] mag;
	logic [WIDE_W-1:0] scaled;
	logic              over;
	logic              ge;

	assign mag    = num[WIDE_W-1] ? -num : num;
	assign scaled = mag << 16;
	assign over   = (scaled >= (den << 32));
	assign ge     = (rem_q >= sub_q);
	assign busy   = busy_q;

	always_comb begin
		if (neg_q) begin
			slope = (q_q > 33'h0_8000_0000) ? 32'sh8000_0000 : -signed'(q_q[31:0]);
		end else begin
			slope = (q_q > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(q_q[31:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[WIDE_W-1];
			rem_q <= scaled;
			sub_q <= den << 31;
			q_q   <= over ? 33'h1_0000_0000 : 33'h0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - sub_q;
			end
			sub_q <= sub_q >> 1;
			q_q   <= {q_q[31:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !over;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/rwrs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwrs_back
// Execution side: Welford update, window ring and sums, wide products and
// slope divisions, then the result register.
// ----------------------------------------------------------------------------
module rwrs_back #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   queue_valid,
	output logic                   queue_ready,
	input  rwrs_pkg::rwrs_item_t   queue_item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output rwrs_pkg::rwrs_result_t result
);
	import rwrs_pkg::*;

	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SLOT_W = $clog2(WINDOW_DEPTH);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_MDIV    = 9'b000000010,
		ST_DIFF    = 9'b000000100,
		ST_PROD    = 9'b000001000,
		ST_ACC     = 9'b000010000,
		ST_MUL     = 9'b000100000,
		ST_SLAUNCH = 9'b001000000,
		ST_SWAIT   = 9'b010000000,
		ST_DONE    = 9'b100000000
	} state_t;

	state_t state_q;

	// Accumulated state.
	logic [31:0]              count_q;
	logic signed [MEAN_W-1:0] mean_x_q, mean_y_q;
	logic signed [MOM_W-1:0]  cm_q, pm_q;
	logic [FILL_W-1:0]        fill_q;
	logic [SLOT_W-1:0]        slot_q;
	logic signed [SUM_W-1:0]  sum_y_q, sum_x_q, sum_xy_q, sum_xx_q;

	// Per-item working registers.
	logic signed [31:0]       y_q, x_q;
	logic signed [DIFF_W-1:0] dx_q, ex_q, ey_q;
	logic signed [SUM_W-1:0]  xy_new_q, xx_new_q, xy_old_q, xx_old_q;
	logic [47:0]              pc_q, pp_q;
	logic                     pc_neg_q, pp_neg_q;
	logic [1:0]               mul_idx_q, part_q;
	logic [WIDE_W-1:0]        acc_q;
	logic signed [WIDE_W-1:0] num_q, den_q;
	logic                     tvalid_q, wvalid_q;
	rwrs_result_t             cache_q, out_q;
	logic                     out_valid_q;

	// Combinational helpers.
	logic                     start_item;
	logic [31:0]              count_next;
	logic signed [DIFF_W-1:0] xs_in, ys_in, xs_q, ys_q;
	logic signed [DIFF_W-1:0] qx, qy;
	logic                     mdx_busy, mdy_busy, tq_busy, wq_busy;
	logic signed [31:0]       tslope, wslope;
	logic [PAIR_W-1:0]        old_pair;
	logic signed [31:0]       old_y, old_x;
	logic signed [63:0]       pxy, pxx, oxy, oxx;
	logic [65:0]              pc_full, pp_full;
	logic                     full;
	logic signed [63:0]       opa, opb;
	logic [63:0]              mag_a, mag_b, ns_w, pp;
	logic [31:0]              half_a, half_b;
	logic [WIDE_W-1:0]        pp_sh, acc_sum, prod_w;
	logic signed [MOM_W-1:0]  term_c, term_p;

	function automatic logic signed [63:0] trunc16(input logic signed [63:0] v);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = m >> 16;
		return v[63] ? -signed'(m) : signed'(m);
	endfunction

	function automatic logic [32:0] mag_hi(input logic signed [DIFF_W-1:0] v);
		logic [DIFF_W-1:0] m;
		m = v[DIFF_W-1] ? -v : v;
		return m[DIFF_W-1:16];
	endfunction

	function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
	                                               input logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

	assign queue_ready = (state_q == ST_IDLE);
	assign start_item  = queue_valid && queue_ready && !queue_item.skip;
	assign count_next  = (count_q == COUNT_MAX) ? count_q : count_q + 32'd1;
	assign xs_in       = {queue_item.predictor[31], queue_item.predictor, 16'h0};
	assign ys_in       = {queue_item.response[31], queue_item.response, 16'h0};
	assign xs_q        = {x_q[31], x_q, 16'h0};
	assign ys_q        = {y_q[31], y_q, 16'h0};
	assign old_y       = old_pair[63:32];
	assign old_x       = old_pair[31:0];
	assign full        = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign result_valid = out_valid_q;
	assign result       = out_q;

	rwrs_sdiv u_mdiv_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_item),
		.dividend (xs_in - {mean_x_q[MEAN_W-1], mean_x_q}),
		.divisor  (count_next),
		.busy     (mdx_busy),
		.quotient (qx)
	);

	rwrs_sdiv u_mdiv_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_item),
		.dividend (ys_in - {mean_y_q[MEAN_W-1], mean_y_q}),
		.divisor  (count_next),
		.busy     (mdy_busy),
		.quotient (qy)
	);

	rwrs_ram #(.WIDTH(PAIR_W), .DEPTH(WINDOW_DEPTH)) u_ring (
		.clk   (clk),
		.we    (state_q == ST_ACC),
		.waddr (slot_q),
		.wdata ({y_q, x_q}),
		.re    (start_item),
		.raddr (slot_q),
		.rdata (old_pair)
	);

	rwrs_qdiv u_tdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SLAUNCH),
		.num    (WIDE_W'(cm_q)),
		.den    (WIDE_W'(pm_q)),
		.busy   (tq_busy),
		.slope  (tslope)
	);

	rwrs_qdiv u_wdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == ST_SLAUNCH),
		.num    (num_q),
		.den    (den_q),
		.busy   (wq_busy),
		.slope  (wslope)
	);

	// Products of the moment and window terms.
	always_comb begin
		pxy     = x_q * y_q;
		pxx     = x_q * x_q;
		oxy     = old_x * old_y;
		oxx     = old_x * old_x;
		pc_full = mag_hi(dx_q) * mag_hi(ey_q);
		pp_full = mag_hi(dx_q) * mag_hi(ex_q);
		term_c  = pc_neg_q ? -signed'({16'h0, pc_q}) : signed'({16'h0, pc_q});
		term_p  = pp_neg_q ? -signed'({16'h0, pp_q}) : signed'({16'h0, pp_q});
	end

	// One 32x32 partial product of the wide window products per cycle.
	always_comb begin
		ns_w = 64'(fill_q) << 16;
		unique case (mul_idx_q)
			2'd0: begin opa = sum_xy_q; opb = signed'(ns_w); end
			2'd1: begin opa = sum_y_q;  opb = sum_x_q;       end
			2'd2: begin opa = sum_xx_q; opb = signed'(ns_w); end
			default: begin opa = sum_x_q; opb = sum_x_q;     end
		endcase
		mag_a  = opa[63] ? 64'(-opa) : 64'(opa);
		mag_b  = opb[63] ? 64'(-opb) : 64'(opb);
		half_a = part_q[1] ? mag_a[63:32] : mag_a[31:0];
		half_b = part_q[0] ? mag_b[63:32] : mag_b[31:0];
		pp     = half_a * half_b;
		unique case (part_q)
			2'd0:    pp_sh = WIDE_W'(pp);
			2'd3:    pp_sh = WIDE_W'(pp) << 64;
			default: pp_sh = WIDE_W'(pp) << 32;
		endcase
		acc_sum = acc_q + pp_sh;
		prod_w  = (opa[63] ^ opb[63]) ? -acc_sum : acc_sum;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				y_q  <= queue_item.response;
				x_q  <= queue_item.predictor;
				dx_q <= xs_in - {mean_x_q[MEAN_W-1], mean_x_q};
			end
			ST_DIFF: begin
				ex_q     <= xs_q - {mean_x_q[MEAN_W-1], mean_x_q};
				ey_q     <= ys_q - {mean_y_q[MEAN_W-1], mean_y_q};
				xy_new_q <= trunc16(pxy);
				xx_new_q <= trunc16(pxx);
			end
			ST_PROD: begin
				pc_q     <= pc_full[63:16];
				pp_q     <= pp_full[63:16];
				pc_neg_q <= dx_q[DIFF_W-1] ^ ey_q[DIFF_W-1];
				pp_neg_q <= dx_q[DIFF_W-1] ^ ex_q[DIFF_W-1];
				xy_old_q <= trunc16(oxy);
				xx_old_q <= trunc16(oxx);
			end
			ST_ACC: begin
				acc_q     <= '0;
				mul_idx_q <= 2'd0;
				part_q    <= 2'd0;
			end
			ST_MUL: begin
				part_q <= part_q + 2'd1;
				if (part_q == 2'd3) begin
					acc_q     <= '0;
					mul_idx_q <= mul_idx_q + 2'd1;
					unique case (mul_idx_q)
						2'd0:    num_q <= signed'(prod_w);
						2'd1:    num_q <= num_q - signed'(prod_w);
						2'd2:    den_q <= signed'(prod_w);
						default: den_q <= den_q - signed'(prod_w);
					endcase
				end else begin
					acc_q <= acc_sum;
				end
			end
			ST_SLAUNCH: begin
				tvalid_q <= (count_q > 32'd1) && !pm_q[MOM_W-1] && (pm_q != '0);
				wvalid_q <= (fill_q >= FILL_W'(2)) && !den_q[WIDE_W-1] && (den_q != '0);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mean_x_q    <= '0;
			mean_y_q    <= '0;
			cm_q        <= '0;
			pm_q        <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			sum_y_q     <= '0;
			sum_x_q     <= '0;
			sum_xy_q    <= '0;
			sum_xx_q    <= '0;
			cache_q     <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The result register loads from the done state and empties when taken.
			out_valid_q <= (state_q == ST_DONE && (!out_valid_q || result_ready))
			               || (out_valid_q && !result_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (queue_valid) begin
						if (queue_item.skip) begin
							state_q <= ST_DONE;
						end else begin
							count_q <= count_next;
							state_q <= ST_MDIV;
						end
					end
				end
				ST_MDIV: begin
					if (!mdx_busy && !mdy_busy) begin
						mean_x_q <= mean_x_q + qx[MEAN_W-1:0];
						mean_y_q <= mean_y_q + qy[MEAN_W-1:0];
						state_q  <= ST_DIFF;
					end
				end
				ST_DIFF: state_q <= ST_PROD;
				ST_PROD: state_q <= ST_ACC;
				ST_ACC: begin
					cm_q     <= sat_add(cm_q, term_c);
					pm_q     <= sat_add(pm_q, term_p);
					// A full window drops its oldest pair as the new one enters.
					sum_y_q  <= sum_y_q + SUM_W'(y_q) - (full ? SUM_W'(old_y) : '0);
					sum_x_q  <= sum_x_q + SUM_W'(x_q) - (full ? SUM_W'(old_x) : '0);
					sum_xy_q <= sum_xy_q + xy_new_q - (full ? xy_old_q : '0);
					sum_xx_q <= sum_xx_q + xx_new_q - (full ? xx_old_q : '0);
					if (!full) begin
						fill_q <= fill_q + FILL_W'(1);
					end
					slot_q   <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
					            : slot_q + SLOT_W'(1);
					state_q  <= ST_MUL;
				end
				ST_MUL: begin
					if (part_q == 2'd3 && mul_idx_q == 2'd3) begin
						state_q <= ST_SLAUNCH;
					end
				end
				ST_SLAUNCH: state_q <= ST_SWAIT;
				ST_SWAIT: begin
					if (!tq_busy && !wq_busy) begin
						cache_q <= '{count: count_q,
						             total_slope: tvalid_q ? tslope : 32'sd0,
						             total_valid: tvalid_q,
						             window_slope: wvalid_q ? wslope : 32'sd0,
						             window_valid: wvalid_q};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || result_ready) begin
						out_q   <= cache_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/running_and_window_regression_slope_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// running_and_window_regression_slope_top
// Running Welford slope and sliding-window least-squares slope of y on x.
// ----------------------------------------------------------------------------
// Requests arrive on the sample channel (sample_valid / sample_ready) as a
// Q16.16 response and predictor plus a skip flag. Every request yields one
// result on the result channel (result_valid / result_ready): the sample
// count and the all-time and window slopes in Q16.16 with valid flags.
// A two-entry queue takes requests while the back end works, so the input
// can stay ready while a result waits to be taken, until the queue is full.
// A counted request passes the serial mean dividers (one quotient bit per
// cycle), the wide window products built from 32x32 partial products, the
// serial slope dividers and the sequencing states between them. A skipped
// request returns the last result. Items are processed one at a time, in
// order. Reset clears all statistics and empties the window; the ring RAM
// needs no clearing as its read data is used only once the window is full.
// When the receiver stalls, the result register holds, the back end waits
// with its next result, and the queue fills and then drops sample_ready.
// ----------------------------------------------------------------------------
module running_and_window_regression_slope_top #(
	parameter int WINDOW_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic signed [31:0] response_sample,
	input  logic signed [31:0] predictor_sample,
	input  logic               skip_sample,
	output logic               result_valid,
	input  logic               result_ready,
	output logic [31:0]        sample_count,
	output logic signed [31:0] total_slope,
	output logic               total_slope_valid,
	output logic signed [31:0] window_slope,
	output logic               window_slope_valid
);
	import rwrs_pkg::*;

	logic         queue_valid;
	logic         queue_ready;
	rwrs_item_t   queue_item;
	rwrs_result_t result;

	rwrs_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.sample_valid     (sample_valid),
		.sample_ready     (sample_ready),
		.response_sample  (response_sample),
		.predictor_sample (predictor_sample),
		.skip_sample      (skip_sample),
		.queue_valid      (queue_valid),
		.queue_ready      (queue_ready),
		.queue_item       (queue_item)
	);

	rwrs_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.queue_valid  (queue_valid),
		.queue_ready  (queue_ready),
		.queue_item   (queue_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	assign sample_count       = result.count;
	assign total_slope        = result.total_slope;
	assign total_slope_valid  = result.total_valid;
	assign window_slope       = result.window_slope;
	assign window_slope_valid = result.window_valid;

	a_total_needs_two : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && total_slope_valid |-> sample_count > 32'd1)
		else $error("total slope valid with fewer than two samples");

	a_window_needs_two : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && window_slope_valid |-> sample_count > 32'd1)
		else $error("window slope valid with fewer than two samples");

	a_total_zero : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !total_slope_valid |-> total_slope == 32'sd0)
		else $error("invalid total slope is not zero");

	a_window_zero : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !window_slope_valid |-> window_slope == 32'sd0)
		else $error("invalid window slope is not zero");

endmodule
